// File: rtl/rlybnk_pkg.sv
// Shared types, codes and helpers for the relay bank with auto-off timers.
package rlybnk_pkg;

	localparam int RELAY_COUNT_DEF = 16;
	localparam int BANK_SIZE_DEF   = 8;
	localparam int TIMER_BITS_DEF  = 16;

	localparam int MODE_W     = 2;
	localparam int IDX_W      = 4;
	localparam int DUR_W      = 16;
	localparam int MASK_W     = 16;
	localparam int REM_W      = 16;
	localparam int PORT_W     = 8;
	localparam int REG_IDX_W  = 1;
	localparam int REG_DATA_W = 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_BANK0 = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_BANK1 = 1'b1;

	// classified request codes
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_ON     = 3'd1;
	localparam logic [OP_W-1:0] OP_OFF    = 3'd2;
	localparam logic [OP_W-1:0] OP_TOGGLE = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd4; // rejected, reports countdown
	localparam logic [OP_W-1:0] OP_NULL   = 3'd5; // rejected, reports zero

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [DUR_W-1:0] dur;
	} req_t;

	// relay lies in a bank that exists and is present
	function automatic logic bank_ok(input int unsigned idx, input int unsigned bsize,
			input int unsigned count, input logic p0, input logic p1);
		logic r;
		r = 1'b0;
		if (idx < count) begin
			if (idx < bsize)
				r = p0;
			else if (idx < 2 * bsize)
				r = p1;
		end
		return r;
	endfunction

endpackage

// File: rtl/rlybnk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlybnk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rlybnk_front.sv
// Front end: accepts requests and classifies them against bank presence.
module rlybnk_front import rlybnk_pkg::*; #(
	parameter int RELAY_COUNT = RELAY_COUNT_DEF,
	parameter int BANK_SIZE   = BANK_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bank0_present,
	input  logic              bank1_present,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [IDX_W-1:0]  relay_index,
	input  logic [DUR_W-1:0]  duration_seconds,
	output logic              req_valid,
	input  logic              req_ready,
	output req_t              req
);

	logic vld_s1;
	req_t req_s1;
	req_t cls;
	logic in_range;
	logic ok;

	always_comb begin
		in_range = 32'(relay_index) < RELAY_COUNT;
		ok = bank_ok(32'(relay_index), BANK_SIZE, RELAY_COUNT, bank0_present, bank1_present);
		cls.idx = relay_index;
		cls.dur = duration_seconds;
		cls.op  = OP_NULL;
		unique case (mode)
			MODE_TICK:   cls.op = (bank0_present || bank1_present) ? OP_TICK : OP_NULL;
			MODE_ON:     cls.op = OP_ON;
			MODE_OFF:    cls.op = OP_OFF;
			MODE_TOGGLE: cls.op = OP_TOGGLE;
			default:     cls.op = OP_NULL;
		endcase
		if (mode != MODE_TICK) begin
			if (!in_range)
				cls.op = OP_NULL;
			else if (!ok)
				cls.op = OP_PEEK;
		end
	end

	assign in_ready  = !vld_s1 || req_ready;
	assign req_valid = vld_s1;
	assign req       = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			req_s1 <= cls;
	end

endmodule

// File: rtl/rlybnk_queue.sv
// Two-entry request queue between front end and executor.
module rlybnk_queue import rlybnk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  req_t push_req,
	output logic pop_valid,
	input  logic pop_ready,
	output req_t pop_req
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_req    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_req;
	end

endmodule

// File: rtl/rlybnk_back.sv
// Executor: carries out commands, sweeps countdowns on ticks, holds the result.
module rlybnk_back import rlybnk_pkg::*; #(
	parameter int RELAY_COUNT = RELAY_COUNT_DEF,
	parameter int BANK_SIZE   = BANK_SIZE_DEF,
	parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              bank0_present,
	input  logic              bank1_present,
	input  logic              q_valid,
	output logic              q_ready,
	input  req_t              q_req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              accepted,
	output logic [MASK_W-1:0] relay_on_mask,
	output logic [MASK_W-1:0] expired_mask,
	output logic [REM_W-1:0]  remaining_seconds,
	output logic [PORT_W-1:0] port_low_drive,
	output logic [PORT_W-1:0] port_high_drive
);

	localparam int AW    = $clog2(RELAY_COUNT);
	localparam int XW0   = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
	localparam int XW    = (XW0 > REM_W) ? XW0 : REM_W;
	localparam int EXT_W = RELAY_COUNT + BANK_SIZE + PORT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CMD   = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]             state_q;
	req_t                   req_q;
	logic [AW-1:0]          cnt_q;
	logic                   sv_s2;
	logic [AW-1:0]          si_s2;
	logic [RELAY_COUNT-1:0] on_q;
	logic [RELAY_COUNT-1:0] exp_q;
	logic [RELAY_COUNT-1:0] vbit_q;
	logic                   acc_q;
	logic [REM_W-1:0]       rem_q;

	logic                   out_valid_q;
	logic                   accepted_q;
	logic [MASK_W-1:0]      on_mask_q;
	logic [MASK_W-1:0]      exp_mask_q;
	logic [REM_W-1:0]       remaining_q;
	logic [PORT_W-1:0]      port_lo_q;
	logic [PORT_W-1:0]      port_hi_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [TIMER_BITS-1:0]  ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [TIMER_BITS-1:0]  ram_rdata;

	logic [AW-1:0]          cmd_addr;
	logic [AW-1:0]          use_addr;
	logic [TIMER_BITS-1:0]  cd;
	logic [TIMER_BITS-1:0]  cd_dec;
	logic                   dec_go;
	logic                   timeout;
	logic                   cmd_go;
	logic [XW-1:0]          dur_x;
	logic [TIMER_BITS-1:0]  dur_sat;
	logic [TIMER_BITS-1:0]  new_cd;
	logic [XW-1:0]          rem_x;
	logic [REM_W-1:0]       rem_sat;
	logic                   load_out;
	logic [EXT_W-1:0]       on_ext;
	logic [PORT_W-1:0]      port_lo;
	logic [PORT_W-1:0]      port_hi;

	rlybnk_ram #(
		.WIDTH(TIMER_BITS),
		.DEPTH(RELAY_COUNT)
	) u_cd_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		cmd_addr = AW'(req_q.idx);
		use_addr = (state_q == ST_CMD) ? cmd_addr : si_s2;
		// never-written entries read as disarmed
		cd       = vbit_q[use_addr] ? ram_rdata : '0;
		cd_dec   = cd - 1'b1;
		dec_go   = sv_s2 && on_q[si_s2] && (cd != '0) &&
			bank_ok(32'(si_s2), BANK_SIZE, RELAY_COUNT, bank0_present, bank1_present);
		timeout  = dec_go && (cd_dec == '0);
		cmd_go   = (state_q == ST_CMD) &&
			(req_q.op == OP_ON || req_q.op == OP_OFF || req_q.op == OP_TOGGLE);

		dur_x   = XW'(req_q.dur);
		dur_sat = (dur_x > XW'({TIMER_BITS{1'b1}})) ? '1 : dur_x[TIMER_BITS-1:0];
		new_cd  = (req_q.op == OP_ON) ? dur_sat : '0;

		rem_x   = XW'(cmd_go ? new_cd : cd);
		rem_sat = (rem_x > XW'({REM_W{1'b1}})) ? '1 : rem_x[REM_W-1:0];

		ram_we    = dec_go || cmd_go;
		ram_waddr = cmd_go ? cmd_addr : si_s2;
		ram_wdata = cmd_go ? new_cd : cd_dec;
		ram_raddr = (state_q == ST_SWEEP) ? cnt_q : AW'(q_req.idx);

		q_ready  = state_q == ST_IDLE;
		load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

		// port bytes are active low; bits past the bank size stay off
		on_ext = EXT_W'(on_q);
		for (int b = 0; b < PORT_W; b++) begin
			port_lo[b] = !((b < BANK_SIZE) && on_ext[b]);
			port_hi[b] = !((b < BANK_SIZE) && on_ext[BANK_SIZE + b]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sv_s2       <= 1'b0;
			on_q        <= '0;
			vbit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			sv_s2 <= state_q == ST_SWEEP;
			if (ram_we)
				vbit_q[ram_waddr] <= 1'b1;
			if (timeout)
				on_q[si_s2] <= 1'b0;
			if (cmd_go) begin
				case (req_q.op)
					OP_ON:     on_q[cmd_addr] <= 1'b1;
					OP_OFF:    on_q[cmd_addr] <= 1'b0;
					OP_TOGGLE: on_q[cmd_addr] <= !on_q[cmd_addr];
					default:   on_q[cmd_addr] <= on_q[cmd_addr];
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_req.op == OP_TICK)
							state_q <= ST_SWEEP;
						else if (q_req.op == OP_NULL)
							state_q <= ST_DONE;
						else
							state_q <= ST_CMD;
					end
				end
				ST_CMD:   state_q <= ST_DONE;
				ST_SWEEP: begin
					if (cnt_q == AW'(RELAY_COUNT - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			req_q <= q_req;
			cnt_q <= '0;
			exp_q <= '0;
			acc_q <= q_req.op == OP_TICK;
			rem_q <= '0;
		end
		if (state_q == ST_SWEEP) begin
			cnt_q <= cnt_q + 1'b1;
			si_s2 <= cnt_q;
		end
		if (timeout)
			exp_q[si_s2] <= 1'b1;
		if (state_q == ST_CMD) begin
			acc_q <= cmd_go;
			rem_q <= rem_sat;
		end
		if (load_out) begin
			accepted_q  <= acc_q;
			on_mask_q   <= MASK_W'(on_q);
			exp_mask_q  <= MASK_W'(exp_q);
			remaining_q <= rem_q;
			port_lo_q   <= port_lo;
			port_hi_q   <= port_hi;
		end
	end

	assign out_valid         = out_valid_q;
	assign accepted          = accepted_q;
	assign relay_on_mask     = on_mask_q;
	assign expired_mask      = exp_mask_q;
	assign remaining_seconds = remaining_q;
	assign port_low_drive    = port_lo_q;
	assign port_high_drive   = port_hi_q;

endmodule

// File: rtl/relay_bank_with_auto_off_timers_unit.sv
// Relay bank with auto-off timers: config registers, front end, queue, executor.
// The executor takes one request at a time; later ones wait in the front end and queue.
// The tick sweep reads and writes one countdown per cycle through the single timer RAM.
// Reset: all relays off, every timer disarmed through per-entry valid bits, both banks
// absent; no clearing pass, requests are taken right after reset.
module relay_bank_with_auto_off_timers_unit import rlybnk_pkg::*; #(
	parameter int RELAY_COUNT = RELAY_COUNT_DEF,
	parameter int BANK_SIZE   = BANK_SIZE_DEF,
	parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [MODE_W-1:0]     mode,
	input  logic [IDX_W-1:0]      relay_index,
	input  logic [DUR_W-1:0]      duration_seconds,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic [MASK_W-1:0]     relay_on_mask,
	output logic [MASK_W-1:0]     expired_mask,
	output logic [REM_W-1:0]      remaining_seconds,
	output logic [PORT_W-1:0]     port_low_drive,
	output logic [PORT_W-1:0]     port_high_drive
);

	logic bank0_q;
	logic bank1_q;
	logic fq_valid;
	logic fq_ready;
	req_t fq_req;
	logic qb_valid;
	logic qb_ready;
	req_t qb_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank0_q <= 1'b0;
			bank1_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BANK0: bank0_q <= wr_data[0];
				REG_BANK1: bank1_q <= wr_data[0];
				default:   bank0_q <= bank0_q;
			endcase
		end
	end

	rlybnk_front #(
		.RELAY_COUNT(RELAY_COUNT),
		.BANK_SIZE  (BANK_SIZE)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.bank0_present   (bank0_q),
		.bank1_present   (bank1_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.relay_index     (relay_index),
		.duration_seconds(duration_seconds),
		.req_valid       (fq_valid),
		.req_ready       (fq_ready),
		.req             (fq_req)
	);

	rlybnk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_req  (fq_req),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_req   (qb_req)
	);

	rlybnk_back #(
		.RELAY_COUNT(RELAY_COUNT),
		.BANK_SIZE  (BANK_SIZE),
		.TIMER_BITS (TIMER_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.bank0_present    (bank0_q),
		.bank1_present    (bank1_q),
		.q_valid          (qb_valid),
		.q_ready          (qb_ready),
		.q_req            (qb_req),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.accepted         (accepted),
		.relay_on_mask    (relay_on_mask),
		.expired_mask     (expired_mask),
		.remaining_seconds(remaining_seconds),
		.port_low_drive   (port_low_drive),
		.port_high_drive  (port_high_drive)
	);

endmodule

// File: test/tb_relay_bank_with_auto_off_timers_unit.sv
// Self-checking testbench for the relay bank unit: predictor-based scoreboard, random stalls.
module tb_relay_bank_with_auto_off_timers_unit;
	import rlybnk_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 5000;
	localparam int SETTLE_TAIL  = 40;
	localparam int REPORT_FIRST = 10;

	typedef struct packed {
		logic              accepted;
		logic [MASK_W-1:0] relay_on_mask;
		logic [MASK_W-1:0] expired_mask;
		logic [REM_W-1:0]  remaining_seconds;
		logic [PORT_W-1:0] port_low_drive;
		logic [PORT_W-1:0] port_high_drive;
	} relay_result_t;

	class relay_bank_scoreboard;
		logic [RELAY_COUNT_DEF-1:0] relay_on;
		logic [TIMER_BITS_DEF-1:0]  countdown [RELAY_COUNT_DEF];
		logic [1:0]                 bank_present;
		relay_result_t              due_results [$];
		int                         mismatches;

		function new();
			relay_on = '0;
			foreach (countdown[i])
				countdown[i] = '0;
			bank_present = 2'b00;
			mismatches = 0;
		endfunction

		function void set_bank(logic [REG_IDX_W-1:0] reg_sel, logic present);
			if (reg_sel == REG_BANK0)
				bank_present[0] = present;
			else
				bank_present[1] = present;
		endfunction

		// advance the relay state by one accepted request and queue its result
		function void apply_request(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
				logic [DUR_W-1:0] dur);
			relay_result_t r;
			int unsigned bank;
			r = '0;
			bank = idx / BANK_SIZE_DEF;
			if (m == MODE_TICK) begin
				if (bank_present != 2'b00) begin
					r.accepted = 1'b1;
					for (int i = 0; i < RELAY_COUNT_DEF; i++) begin
						if (relay_on[i] && countdown[i] != '0 &&
								bank_present[i / BANK_SIZE_DEF]) begin
							countdown[i] = countdown[i] - 1'b1;
							if (countdown[i] == '0) begin
								relay_on[i] = 1'b0;
								r.expired_mask[i] = 1'b1;
							end
						end
					end
				end
			end else begin
				if (bank_present[bank]) begin
					r.accepted = 1'b1;
					case (m)
						MODE_ON: begin
							relay_on[idx] = 1'b1;
							countdown[idx] = dur;
						end
						MODE_OFF: begin
							relay_on[idx] = 1'b0;
							countdown[idx] = '0;
						end
						default: begin
							relay_on[idx] = ~relay_on[idx];
							countdown[idx] = '0;
						end
					endcase
				end
				// rejected commands still report the addressed countdown
				r.remaining_seconds = countdown[idx];
			end
			r.relay_on_mask = relay_on;
			r.port_low_drive = ~relay_on[BANK_SIZE_DEF-1:0];
			r.port_high_drive = ~relay_on[2*BANK_SIZE_DEF-1:BANK_SIZE_DEF];
			due_results.push_back(r);
		endfunction

		function void check_result(relay_result_t got);
			relay_result_t want;
			bit bad;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_FIRST)
					$display("unexpected result: acc=%0b on=%h exp=%h rem=%0d lo=%h hi=%h",
						got.accepted, got.relay_on_mask, got.expired_mask,
						got.remaining_seconds, got.port_low_drive, got.port_high_drive);
				return;
			end
			want = due_results.pop_front();
			bad = 1'b0;
			if (got.accepted !== want.accepted) bad = 1'b1;
			if (got.relay_on_mask !== want.relay_on_mask) bad = 1'b1;
			if (got.expired_mask !== want.expired_mask) bad = 1'b1;
			if (got.remaining_seconds !== want.remaining_seconds) bad = 1'b1;
			if (got.port_low_drive !== want.port_low_drive) bad = 1'b1;
			if (got.port_high_drive !== want.port_high_drive) bad = 1'b1;
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_FIRST) begin
					$display("mismatch at %0t", $realtime);
					$display("  expected acc=%0b on=%h exp=%h rem=%0d lo=%h hi=%h",
						want.accepted, want.relay_on_mask, want.expired_mask,
						want.remaining_seconds, want.port_low_drive, want.port_high_drive);
					$display("  actual   acc=%0b on=%h exp=%h rem=%0d lo=%h hi=%h",
						got.accepted, got.relay_on_mask, got.expired_mask,
						got.remaining_seconds, got.port_low_drive, got.port_high_drive);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [REG_DATA_W-1:0] wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [MODE_W-1:0]     mode = MODE_TICK;
	logic [IDX_W-1:0]      relay_index = '0;
	logic [DUR_W-1:0]      duration_seconds = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  accepted;
	logic [MASK_W-1:0]     relay_on_mask;
	logic [MASK_W-1:0]     expired_mask;
	logic [REM_W-1:0]      remaining_seconds;
	logic [PORT_W-1:0]     port_low_drive;
	logic [PORT_W-1:0]     port_high_drive;

	bit steady_flow = 1'b0;
	int quiet_cycles = 0;
	relay_bank_scoreboard sb = new();

	relay_bank_with_auto_off_timers_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.wr_en             (wr_en),
		.wr_index          (wr_index),
		.wr_data           (wr_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.relay_index       (relay_index),
		.duration_seconds  (duration_seconds),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.accepted          (accepted),
		.relay_on_mask     (relay_on_mask),
		.expired_mask      (expired_mask),
		.remaining_seconds (remaining_seconds),
		.port_low_drive    (port_low_drive),
		.port_high_drive   (port_high_drive)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= steady_flow || ($urandom_range(0, 99) >= 27);
	end

	// result check runs before the new request is noted; latency keeps them apart anyway
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(relay_result_t'{accepted, relay_on_mask, expired_mask,
					remaining_seconds, port_low_drive, port_high_drive});
			if (in_valid && in_ready)
				sb.apply_request(mode, relay_index, duration_seconds);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		do
			@(posedge clk);
		while (quiet_cycles < QUIET_LIMIT);
		$display("tb_relay_bank_with_auto_off_timers_unit failed");
		$finish;
	end

	// leaves in_valid high on return; drain_results lowers it, the next call only when it pauses
	task automatic send_request(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
			input logic [DUR_W-1:0] dur);
		while (!steady_flow && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		relay_index <= idx;
		duration_seconds <= dur;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_banks(input logic b0, input logic b1);
		wr_en <= 1'b1;
		wr_index <= REG_BANK0;
		wr_data <= b0;
		@(posedge clk);
		wr_index <= REG_BANK1;
		wr_data <= b1;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.set_bank(REG_BANK0, b0);
		sb.set_bank(REG_BANK1, b1);
	endtask

	initial begin : stimulus
		int phase_len [6];
		logic [1:0] banks;
		logic [MODE_W-1:0] m;
		logic [IDX_W-1:0] ri;
		logic [DUR_W-1:0] d;
		int unsigned pick;

		phase_len = '{300, 250, 250, 350, 100, 400};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no bank present: everything rejected
		set_banks(1'b0, 1'b0);
		send_request(MODE_TICK, 4'd0, 16'd0);
		send_request(MODE_ON, 4'd2, 16'd5);
		send_request(MODE_TOGGLE, 4'd12, 16'd0);
		drain_results();

		set_banks(1'b1, 1'b1);
		send_request(MODE_ON, 4'd0, 16'd0);
		send_request(MODE_ON, 4'd15, 16'hFFFF);
		send_request(MODE_ON, 4'd7, 16'd3);
		send_request(MODE_ON, 4'd8, 16'd1);
		send_request(MODE_ON, 4'd9, 16'd2);
		send_request(MODE_TICK, 4'd15, 16'hFFFF);
		send_request(MODE_TOGGLE, 4'd3, 16'd0);
		send_request(MODE_TOGGLE, 4'd3, 16'd0);
		send_request(MODE_TOGGLE, 4'd7, 16'd0);
		send_request(MODE_OFF, 4'd15, 16'hFFFF);
		send_request(MODE_OFF, 4'd4, 16'd0);
		send_request(MODE_ON, 4'd10, 16'hAAAA);
		send_request(MODE_ON, 4'd1, 16'd2);
		drain_results();

		// upper bank absent: its timers hold, commands there only peek
		set_banks(1'b1, 1'b0);
		send_request(MODE_TICK, 4'd0, 16'd0);
		send_request(MODE_ON, 4'd9, 16'd7);
		send_request(MODE_TICK, 4'd0, 16'd0);
		drain_results();

		set_banks(1'b0, 1'b1);
		send_request(MODE_TICK, 4'd0, 16'd0);
		send_request(MODE_OFF, 4'd0, 16'd0);
		send_request(MODE_ON, 4'd14, 16'h5555);
		drain_results();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0, 3: banks = 2'b11;
				1: banks = 2'b01;
				2: banks = 2'b10;
				4: banks = 2'b00;
				default: banks = 2'($urandom_range(1, 3));
			endcase
			set_banks(banks[0], banks[1]);
			steady_flow = (p == 3);
			for (int n = 0; n < phase_len[p]; n++) begin
				pick = $urandom_range(0, 99);
				ri = 4'($urandom_range(0, 15));
				d = 16'($urandom());
				if (pick < 40)
					m = MODE_TICK;
				else if (pick < 70)
					m = MODE_ON;
				else if (pick < 85)
					m = MODE_OFF;
				else
					m = MODE_TOGGLE;
				// short timers so that expiry happens often
				if (m == MODE_ON) begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						d = '0;
					else if (pick == 2)
						d = 16'hFFFF;
					else if (pick > 2)
						d = 16'($urandom_range(1, 6));
				end
				send_request(m, ri, d);
			end
			drain_results();
		end

		steady_flow = 1'b0;
		repeat (SETTLE_TAIL) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("tb_relay_bank_with_auto_off_timers_unit passed");
		else
			$display("tb_relay_bank_with_auto_off_timers_unit failed");
		$finish;
	end

endmodule

// File: relay_bank_with_auto_off_timers_unit.f
rtl/rlybnk_pkg.sv
rtl/rlybnk_ram.sv
rtl/rlybnk_front.sv
rtl/rlybnk_queue.sv
rtl/rlybnk_back.sv
rtl/relay_bank_with_auto_off_timers_unit.sv
test/tb_relay_bank_with_auto_off_timers_unit.sv
